/* src/bsc_pkg.sv */
package bsc_pkg;

    localparam int unsigned AdcW    = 20;
    localparam int unsigned CfgW    = 64;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned MulW    = 32;
    localparam int unsigned DivW    = 64;

    localparam logic [CfgIdxW-1:0] REG_CAL_T  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CAL_P1 = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CAL_P2 = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_CAL_P3 = 2'd3;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // datapath steps, sequenced by the controller
    typedef enum logic [5:0] {
        ST_IDLE,
        // temperature
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
        // pressure, before division
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_P9, ST_P10, ST_P11, ST_P12,
        // division
        ST_DIV_START, ST_DIV_RUN, ST_DIV_FIX,
        // after division
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        state_t step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic div_zero;
    } dp_sts_t;

endpackage

/* src/bsc_mul64.sv */
// 64x64 wrapping product built from three 32x32 partial products, one per cycle.
// done is raised with the product on prod.
module bsc_mul64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] pp_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pp_next;

    // partial product select: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        ma = a_reg[31:0];
        mb = b_reg[31:0];
        case (cnt_reg)
            3'd1:    mb = b_reg[63:32];
            3'd2:    ma = a_reg[63:32];
            default: ;
        endcase
        pp_next = ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= pp_next;
            case (cnt_reg)
                3'd1:    acc_reg <= pp_reg;
                3'd2:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                3'd3:    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                default: ;
            endcase
        end
    end

    assign done = busy_reg && (cnt_reg == 3'd3);
    assign prod = acc_reg + {pp_reg[31:0], 32'd0};
endmodule

/* src/bsc_div64.sv */
// Unsigned 64/64 restoring divider, one quotient bit per cycle.
module bsc_div64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic [63:0] quo
);
    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {r_reg, q_reg[63]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                r_reg <= diff[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

/* src/bsc_datapath.sv */
// Compensation datapath: calibration registers, working registers, shared
// 64-bit multiplier and divider.
module bsc_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [bsc_pkg::CfgW-1:0]       cfg_data,
    input  logic [bsc_pkg::AdcW-1:0]       adc_in,
    input  bsc_pkg::dp_cmd_t               cmd,
    output bsc_pkg::dp_sts_t               sts,
    output logic                           mul_done,
    output logic signed [31:0]             temp_out,
    output logic [31:0]                    press_out,
    output logic                           dz_out
);
    logic [47:0] calt_reg;
    logic [63:0] calp1_reg;
    logic [63:0] calp2_reg;
    logic [15:0] calp3_reg;
    logic [31:0] tfine_reg;
    logic [19:0] adc_reg;
    logic [63:0] v1_reg;
    logic [63:0] v2_reg;
    logic [63:0] x_reg;
    logic [63:0] p_reg;
    logic        neg_reg;
    logic [31:0] temp_reg;
    logic [31:0] press_reg;
    logic        dz_reg;

    logic        mstart;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mp;
    logic        dstart;
    logic        dbusy;
    logic [63:0] dq;
    logic [63:0] dnum;
    logic [63:0] dden;

    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] p6;
    logic [63:0] p7;
    logic [63:0] p8;
    logic [63:0] p9;
    logic [63:0] tf64;
    logic [63:0] v1t;
    logic [63:0] ps13;
    logic [31:0] b_t;

    always_comb
    begin
        t1   = {48'd0, calt_reg[15:0]};
        t2   = {{48{calt_reg[31]}}, calt_reg[31:16]};
        t3   = {{48{calt_reg[47]}}, calt_reg[47:32]};
        p1   = {48'd0, calp1_reg[15:0]};
        p2   = {{48{calp1_reg[31]}}, calp1_reg[31:16]};
        p3   = {{48{calp1_reg[47]}}, calp1_reg[47:32]};
        p4   = {{48{calp1_reg[63]}}, calp1_reg[63:48]};
        p5   = {{48{calp2_reg[15]}}, calp2_reg[15:0]};
        p6   = {{48{calp2_reg[31]}}, calp2_reg[31:16]};
        p7   = {{48{calp2_reg[47]}}, calp2_reg[47:32]};
        p8   = {{48{calp2_reg[63]}}, calp2_reg[63:48]};
        p9   = {{48{calp3_reg[15]}}, calp3_reg};
        tf64 = {{32{tfine_reg[31]}}, tfine_reg};
        v1t  = tf64 - 64'd128000;
        ps13 = 64'($signed(p_reg) >>> 13);
        // b = (adc>>4) - T1, 32-bit
        b_t  = 32'({16'd0, adc_reg[19:4]}) - t1[31:0];
    end

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calt_reg  <= '0;
            calp1_reg <= '0;
            calp2_reg <= '0;
            calp3_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_CAL_T:  calt_reg  <= cfg_data[47:0];
                bsc_pkg::REG_CAL_P1: calp1_reg <= cfg_data;
                bsc_pkg::REG_CAL_P2: calp2_reg <= cfg_data;
                bsc_pkg::REG_CAL_P3: calp3_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select per step
    always_comb
    begin
        mstart = 1'b1;
        ma     = '0;
        mb     = '0;
        case (cmd.step)
            bsc_pkg::ST_T0: begin ma = x_reg; mb = t2; end
            bsc_pkg::ST_T1: begin ma = x_reg; mb = x_reg; end
            bsc_pkg::ST_T2: begin ma = v2_reg; mb = t3; end
            bsc_pkg::ST_T3: begin ma = {32'd0, tfine_reg}; mb = 64'd5; end
            bsc_pkg::ST_P0: begin ma = v1_reg; mb = v1_reg; end
            bsc_pkg::ST_P1: begin ma = x_reg; mb = p6; end
            bsc_pkg::ST_P2: begin ma = v1_reg; mb = p5; end
            bsc_pkg::ST_P3: begin ma = x_reg; mb = p3; end
            bsc_pkg::ST_P4: begin ma = v1_reg; mb = p2; end
            bsc_pkg::ST_P5: begin ma = x_reg; mb = p1; end
            bsc_pkg::ST_P6: begin ma = x_reg; mb = 64'd3125; end
            bsc_pkg::ST_Q0: begin ma = p9; mb = ps13; end
            bsc_pkg::ST_Q1: begin ma = x_reg; mb = ps13; end
            bsc_pkg::ST_Q2: begin ma = p8; mb = p_reg; end
            default: mstart = 1'b0;
        endcase
        mstart = mstart && cmd.load;
    end

    bsc_mul64 u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (ma),
        .b     (mb),
        .done  (mul_done),
        .prod  (mp)
    );

    assign dnum   = x_reg[63] ? (64'd0 - x_reg) : x_reg;
    assign dden   = v1_reg[63] ? (64'd0 - v1_reg) : v1_reg;
    assign dstart = (cmd.step == bsc_pkg::ST_DIV_START);

    bsc_div64 u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dden),
        .busy  (dbusy),
        .quo   (dq)
    );

    assign sts.div_done = !dbusy;
    assign sts.div_zero = (v1_reg == 64'd0);

    // fine temperature is architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tfine_reg <= '0;
        else if (mul_done && cmd.step == bsc_pkg::ST_T2)
            tfine_reg <= v1_reg[31:0] + 32'($signed(mp[31:0]) >>> 14);
    end

    // working registers; load marks the first cycle of a step,
    // mul_done the capture of its product
    always_ff @(posedge clk)
    begin
        if (cmd.step == bsc_pkg::ST_IDLE && cmd.load)
        begin
            adc_reg <= adc_in;
            // (adc>>3) - 2*T1, 32-bit signed
            x_reg   <= {{32{1'b0}}, 32'({15'd0, adc_in[19:3]}) - 32'({t1[30:0], 1'b0})};
            // pressure starts from fine temperature - 128000
            v1_reg  <= v1t;
        end
        else
        begin
            case (cmd.step)
                bsc_pkg::ST_T0:
                    if (mul_done)
                    begin
                        v1_reg <= {32'd0, 32'($signed(mp[31:0]) >>> 11)};
                        // b sign extended for 64-bit multiply
                        x_reg  <= {{32{b_t[31]}}, b_t};
                    end
                    else if (cmd.load)
                        ;
                bsc_pkg::ST_T1:
                    if (mul_done)
                        v2_reg <= {{32{mp[31]}}, 32'($signed(mp[31:0]) >>> 12)};
                    else if (cmd.load)
                        v1_reg <= v1_reg;
                default: ;
            endcase
            // v1 of temperature lives in v1_reg low half; b in x_reg
            if (cmd.step == bsc_pkg::ST_T1 && cmd.load)
            begin
                v2_reg <= x_reg;
            end
            case (cmd.step)
                bsc_pkg::ST_T3:
                    if (mul_done)
                        temp_reg <= 32'($signed(mp[31:0] + 32'd128) >>> 8);
                bsc_pkg::ST_T4:
                begin
                    press_reg <= '0;
                    dz_reg    <= 1'b0;
                end
                bsc_pkg::ST_P0:
                    if (mul_done)
                        x_reg <= mp;
                bsc_pkg::ST_P1:
                    if (mul_done)
                        v2_reg <= mp;
                bsc_pkg::ST_P2:
                    if (mul_done)
                        v2_reg <= v2_reg + {mp[46:0], 17'd0} + {p4[28:0], 35'd0};
                bsc_pkg::ST_P3:
                    if (mul_done)
                        p_reg <= 64'($signed(mp) >>> 8);
                bsc_pkg::ST_P4:
                    if (mul_done)
                        x_reg <= 64'h8000_0000_0000 + p_reg + {mp[51:0], 12'd0};
                bsc_pkg::ST_P5:
                    if (mul_done)
                        v1_reg <= 64'($signed(mp) >>> 33);
                // dividend before scaling, ready for the multiply that follows
                bsc_pkg::ST_P7:
                    x_reg <= ((64'd1048576 - {44'd0, adc_reg}) << 31) - v2_reg;
                bsc_pkg::ST_P6:
                    if (mul_done)
                        x_reg <= mp;
                bsc_pkg::ST_DIV_START:
                    neg_reg <= x_reg[63] ^ v1_reg[63];
                bsc_pkg::ST_DIV_FIX:
                    p_reg <= neg_reg ? (64'd0 - dq) : dq;
                bsc_pkg::ST_Q0:
                    if (mul_done)
                        x_reg <= mp;
                bsc_pkg::ST_Q1:
                    if (mul_done)
                        v1_reg <= 64'($signed(mp) >>> 25);
                bsc_pkg::ST_Q2:
                    if (mul_done)
                        v2_reg <= 64'($signed(mp) >>> 19);
                bsc_pkg::ST_Q3:
                    x_reg <= 64'($signed(p_reg + v1_reg + v2_reg) >>> 8)
                             + {p7[59:0], 4'd0};
                bsc_pkg::ST_Q4:
                begin
                    press_reg <= x_reg[31:0];
                    dz_reg    <= 1'b0;
                    temp_reg  <= '0;
                end
                bsc_pkg::ST_P12:
                begin
                    press_reg <= '0;
                    dz_reg    <= 1'b1;
                    temp_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    assign temp_out  = temp_reg;
    assign press_out = press_reg;
    assign dz_out    = dz_reg;
endmodule

/* src/bsc_ctrl.sv */
// Sequencer for one item at a time; holds the result until it is taken.
module bsc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    input  logic              mul_done,
    input  bsc_pkg::dp_sts_t  sts,
    output bsc_pkg::dp_cmd_t  cmd
);
    bsc_pkg::state_t state_reg;
    bsc_pkg::state_t state_next;
    logic            first_reg;
    logic            kind_reg;
    logic            ovalid_reg;
    logic            ovalid_next;
    logic            in_xfer;

    assign in_xfer = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsc_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = (op == bsc_pkg::OP_TEMP) ? bsc_pkg::ST_T0
                                                          : bsc_pkg::ST_P0;
            bsc_pkg::ST_T0: if (mul_done) state_next = bsc_pkg::ST_T1;
            bsc_pkg::ST_T1: if (mul_done) state_next = bsc_pkg::ST_T2;
            bsc_pkg::ST_T2: if (mul_done) state_next = bsc_pkg::ST_T3;
            bsc_pkg::ST_T3: if (mul_done) state_next = bsc_pkg::ST_T4;
            bsc_pkg::ST_T4: state_next = bsc_pkg::ST_DONE;
            bsc_pkg::ST_P0: if (mul_done) state_next = bsc_pkg::ST_P1;
            bsc_pkg::ST_P1: if (mul_done) state_next = bsc_pkg::ST_P2;
            bsc_pkg::ST_P2: if (mul_done) state_next = bsc_pkg::ST_P3;
            bsc_pkg::ST_P3: if (mul_done) state_next = bsc_pkg::ST_P4;
            bsc_pkg::ST_P4: if (mul_done) state_next = bsc_pkg::ST_P5;
            bsc_pkg::ST_P5: if (mul_done) state_next = bsc_pkg::ST_P7;
            bsc_pkg::ST_P7:
                state_next = sts.div_zero ? bsc_pkg::ST_P12 : bsc_pkg::ST_P6;
            bsc_pkg::ST_P6: if (mul_done) state_next = bsc_pkg::ST_DIV_START;
            bsc_pkg::ST_DIV_START: state_next = bsc_pkg::ST_DIV_RUN;
            bsc_pkg::ST_DIV_RUN: if (sts.div_done) state_next = bsc_pkg::ST_DIV_FIX;
            bsc_pkg::ST_DIV_FIX: state_next = bsc_pkg::ST_Q0;
            bsc_pkg::ST_Q0: if (mul_done) state_next = bsc_pkg::ST_Q1;
            bsc_pkg::ST_Q1: if (mul_done) state_next = bsc_pkg::ST_Q2;
            bsc_pkg::ST_Q2: if (mul_done) state_next = bsc_pkg::ST_Q3;
            bsc_pkg::ST_Q3: state_next = bsc_pkg::ST_Q4;
            bsc_pkg::ST_Q4: state_next = bsc_pkg::ST_DONE;
            bsc_pkg::ST_P12: state_next = bsc_pkg::ST_DONE;
            bsc_pkg::ST_DONE:
                if (out_ready) state_next = bsc_pkg::ST_IDLE;
            default: state_next = bsc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = (state_reg == bsc_pkg::ST_IDLE);
        ovalid_next = (state_reg == bsc_pkg::ST_DONE);
        cmd.step    = state_reg;
        cmd.load    = (state_reg == bsc_pkg::ST_IDLE) ? in_xfer : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsc_pkg::ST_IDLE;
            first_reg <= 1'b0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= (state_next != state_reg);
            if (in_xfer)
                kind_reg <= op;
        end
    end

    assign ovalid_reg = ovalid_next;
    assign out_valid  = ovalid_reg;
    assign kind       = kind_reg;
endmodule

/* src/barometric_sensor_compensation.sv */
// Barometric sensor compensation. A temperature result is presented after the
// temperature multiplies, a pressure result after the pressure multiplies and the
// division (which is skipped when the divisor is zero). The 64-bit multiplier is
// shared by all products; the divider is radix-2.
// One item is in flight at a time; the result stays on the output until it is
// transferred, and the next item can be accepted in the cycle after. Load calibration
// while idle.
module barometric_sensor_compensation
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [63:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [19:0]                 adc_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        result_kind,
    output logic signed [31:0]          temperature_centi,
    output logic [31:0]                 pressure_q24_8,
    output logic                        divisor_zero
);
    bsc_pkg::dp_cmd_t cmd;
    bsc_pkg::dp_sts_t sts;
    logic             mul_done;

    bsc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (result_kind),
        .mul_done  (mul_done),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsc_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adc_in    (adc_value),
        .cmd       (cmd),
        .sts       (sts),
        .mul_done  (mul_done),
        .temp_out  (temperature_centi),
        .press_out (pressure_q24_8),
        .dz_out    (divisor_zero)
    );

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_temp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_kind) |-> (pressure_q24_8 == 32'd0 && !divisor_zero))
        else $error("temperature result carries pressure data");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule
